### src/assert_macros.svh
// Assertion macros for the rigidity spectrum intensity modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while in reset
`define RSI_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rsi assertion failed");

// Condition that must never hold
`define RSI_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("rsi forbidden condition seen");

`endif

### src/rsi_pkg.sv
// Types, widths and codes shared by the rigidity spectrum intensity block
package rsi_pkg;
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int N_W = $clog2(TABLE_DEPTH + 1);
	localparam int E_W = 24;
	localparam int I_W = 32;
	localparam int R_W = 24;
	localparam int BPG_W = 16;
	localparam int RES_W = 40;
	localparam int ST_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_REST_ENERGY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGIDITY_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_PER_GV = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SEARCH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 3'd4;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_MISS = 2'd1;
	localparam logic [ST_W-1:0] ST_CLAMP = 2'd2;
	localparam logic [ST_W-1:0] ST_SAT = 2'd3;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	typedef struct packed {
		logic func;
		logic [R_W-1:0] rigidity;
		logic [IDX_W-1:0] entry_index;
		logic [E_W-1:0] entry_energy;
		logic [I_W-1:0] entry_intensity;
	} item_t;

	typedef struct packed {
		logic [E_W-1:0] rest_energy;
		logic [R_W-1:0] rigidity_step;
		logic [BPG_W-1:0] bins_per_gv;
		logic force_search;
		logic [N_W-1:0] entries;
	} regs_t;
endpackage

### src/rsi_if.sv
// Handshake channels of the rigidity spectrum intensity block
interface rsi_req_if import rsi_pkg::*; ();
	logic valid;
	logic ready;
	logic func;
	logic [R_W-1:0] rigidity;
	logic [IDX_W-1:0] entry_index;
	logic [E_W-1:0] entry_energy;
	logic [I_W-1:0] entry_intensity;
	modport source(output valid, func, rigidity, entry_index, entry_energy, entry_intensity,
		input ready);
	modport sink(input valid, func, rigidity, entry_index, entry_energy, entry_intensity,
		output ready);
endinterface

interface rsi_rsp_if import rsi_pkg::*; ();
	logic valid;
	logic ready;
	logic [RES_W-1:0] intensity_per_mev;
	logic [ST_W-1:0] status;
	modport source(output valid, intensity_per_mev, status, input ready);
	modport sink(input valid, intensity_per_mev, status, output ready);
endinterface

interface rsi_cfg_if import rsi_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### src/rsi_front.sv
// Front end: configuration registers and the item queue ahead of the back end
module rsi_front import rsi_pkg::*; (
	input logic clk,
	input logic arst_n,
	rsi_req_if.sink req,
	rsi_cfg_if.sink cfg,
	output regs_t regs,
	output logic item_vld,
	output item_t item,
	input logic item_pop
);
	localparam int Q_DEPTH = 2;

	logic [E_W-1:0] rest_q;
	logic [R_W-1:0] step_q;
	logic [BPG_W-1:0] bpg_q;
	logic force_q;
	logic [N_W-1:0] entries_q;
	item_t fifo_q [Q_DEPTH];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	item_t in_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= 24'd61490;
			step_q <= 24'd655;
			bpg_q <= '0;
			force_q <= 1'b1;
			entries_q <= N_W'(TABLE_DEPTH);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_REST_ENERGY: rest_q <= cfg.data[E_W-1:0];
				CFG_RIGIDITY_STEP: step_q <= cfg.data[R_W-1:0];
				CFG_BINS_PER_GV: bpg_q <= cfg.data[BPG_W-1:0];
				CFG_FORCE_SEARCH: force_q <= cfg.data[0];
				CFG_TABLE_ENTRIES: entries_q <= cfg.data[N_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the entry count to the usable range
	always_comb begin
		regs.rest_energy = rest_q;
		regs.rigidity_step = step_q;
		regs.bins_per_gv = bpg_q;
		regs.force_search = force_q;
		if (entries_q < N_W'(2))
			regs.entries = N_W'(2);
		else if (entries_q > N_W'(TABLE_DEPTH))
			regs.entries = N_W'(TABLE_DEPTH);
		else
			regs.entries = entries_q;
	end

	assign in_item = '{func: req.func, rigidity: req.rigidity, entry_index: req.entry_index,
		entry_energy: req.entry_energy, entry_intensity: req.entry_intensity};
	assign req.ready = (cnt_q != 2'(Q_DEPTH));
	assign push = req.valid && req.ready;
	assign item_vld = (cnt_q != 2'd0);
	assign item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (item_pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(item_pop);
		end
	end
endmodule

### src/rsi_back.sv
// Back end: table memories, square roots, bin search, interpolation and scaling
`include "assert_macros.svh"
module rsi_back import rsi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input regs_t regs,
	input logic item_vld,
	input item_t item,
	output logic item_pop,
	rsi_rsp_if.source rsp
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_T0SQ = 4'd1;
	localparam logic [3:0] S_RSQ = 4'd2;
	localparam logic [3:0] S_SQ1 = 4'd3;
	localparam logic [3:0] S_R2SQ = 4'd4;
	localparam logic [3:0] S_SQ2 = 4'd5;
	localparam logic [3:0] S_SEL = 4'd6;
	localparam logic [3:0] S_SCAN = 4'd7;
	localparam logic [3:0] S_NUM = 4'd8;
	localparam logic [3:0] S_DIV = 4'd9;
	localparam logic [3:0] S_FIX = 4'd10;
	localparam logic [3:0] S_PROD = 4'd11;
	localparam logic [3:0] S_SCALE = 4'd12;
	localparam logic [3:0] S_OUT = 4'd13;

	localparam int SQ_W = 52;
	localparam int NUM_W = 57;

	logic [3:0] st_q;
	item_t it_q;
	logic [E_W-1:0] e_mem [TABLE_DEPTH];
	logic [I_W-1:0] i_mem [TABLE_DEPTH];
	logic [E_W-1:0] e_rd_q, prev_e_q, e0_q, e1_q;
	logic [I_W-1:0] i_rd_q, prev_i_q, i0_q, i1_q;
	logic [47:0] t0sq_q;
	logic [SQ_W-1:0] v_q, res_q, bit_q, trial, res_nx;
	logic [4:0] sq_cnt_q;
	logic [24:0] tkin_q, del_q, sqrt_t;
	logic [25:0] sqrt_v;
	logic [32:0] mul_a, mul_b;
	logic [65:0] mul_p;
	logic [IDX_W-1:0] base_q, rd_addr;
	logic [N_W-1:0] cnt_q, lim_q, rdc_q;
	logic rd_vld_q, dir_q, rd_en;
	logic [ST_W-1:0] stat_q;
	logic [NUM_W-1:0] quo_q;
	logic [E_W-1:0] den_q, rem_q;
	logic [E_W:0] rem_sh;
	logic [5:0] dv_cnt_q;
	logic qneg_q;
	logic [I_W-1:0] intens_q;
	logic sat_q;
	logic [NUM_W-1:0] prod_q;
	logic [RES_W-1:0] out_res_q;
	logic [ST_W-1:0] out_st_q;
	logic [32:0] idiff, imag;
	logic [25:0] ediff, emag;
	logic [E_W:0] ddiff;
	logic [R_W:0] r2;
	logic [15:0] kk;
	logic [NUM_W:0] fix_sum;
	logic [66:0] sc;
	logic [50:0] sc_res;
	logic search;

	assign search = (regs.bins_per_gv == '0) || regs.force_search;
	assign r2 = {1'b0, it_q.rigidity} + {1'b0, regs.rigidity_step};
	assign item_pop = (st_q == S_IDLE) && item_vld;

	// shared multiplier, operands picked by the sequencer step
	always_comb begin
		idiff = {1'b0, i1_q} - {1'b0, i0_q};
		imag = idiff[32] ? (~idiff + 33'd1) : idiff;
		ediff = {1'b0, tkin_q} - {2'b0, e0_q};
		emag = ediff[25] ? (~ediff + 26'd1) : ediff;
		ddiff = {1'b0, e1_q} - {1'b0, e0_q};
		case (st_q)
			S_T0SQ: begin
				mul_a = 33'(regs.rest_energy);
				mul_b = 33'(regs.rest_energy);
			end
			S_RSQ, S_SEL: begin
				mul_a = 33'(it_q.rigidity);
				mul_b = (st_q == S_SEL) ? 33'(regs.bins_per_gv) : 33'(it_q.rigidity);
			end
			S_R2SQ: begin
				mul_a = 33'(r2);
				mul_b = 33'(r2);
			end
			S_NUM: begin
				mul_a = imag;
				mul_b = 33'(emag);
			end
			S_PROD: begin
				mul_a = 33'(intens_q);
				mul_b = 33'(del_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = 66'(mul_a) * 66'(mul_b);
	end

	// one step of the digit-by-digit square root, plus the divider shift, bin index, sums and read address
	always_comb begin
		trial = res_q + bit_q;
		res_nx = (v_q >= trial) ? ((res_q >> 1) + bit_q) : (res_q >> 1);
		sqrt_v = res_nx[25:0] - {2'b0, regs.rest_energy};
		sqrt_t = sqrt_v[24:0];
		rem_sh = {rem_q, quo_q[NUM_W-1]};
		kk = mul_p[39:24];
		fix_sum = {26'b0, i0_q} + {1'b0, quo_q};
		// times 1000 as 1024 - 16 - 8
		sc = {prod_q, 10'b0} - {6'b0, prod_q, 4'b0} - {7'b0, prod_q, 3'b0};
		sc_res = sc[66:16];
		rd_en = (st_q == S_SCAN) && (cnt_q <= lim_q);
		rd_addr = base_q + cnt_q[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (item_pop && (item.func == FUNC_LOAD)) begin
			e_mem[item.entry_index] <= item.entry_energy;
			i_mem[item.entry_index] <= item.entry_intensity;
		end
		if (rd_en) begin
			e_rd_q <= e_mem[rd_addr];
			i_rd_q <= i_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			rd_vld_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (item_vld) begin
						it_q <= item;
						stat_q <= ST_OK;
						sat_q <= 1'b0;
						out_res_q <= '0;
						out_st_q <= ST_OK;
						st_q <= (item.func == FUNC_LOAD) ? S_OUT : S_T0SQ;
					end
				end
				S_T0SQ: begin
					t0sq_q <= mul_p[47:0];
					st_q <= S_RSQ;
				end
				S_RSQ, S_R2SQ: begin
					v_q <= {4'b0, t0sq_q} + mul_p[SQ_W-1:0];
					res_q <= '0;
					bit_q <= SQ_W'(1) << 50;
					sq_cnt_q <= 5'd25;
					st_q <= (st_q == S_RSQ) ? S_SQ1 : S_SQ2;
				end
				S_SQ1, S_SQ2: begin
					if (v_q >= trial)
						v_q <= v_q - trial;
					res_q <= res_nx;
					bit_q <= bit_q >> 2;
					sq_cnt_q <= sq_cnt_q - 5'd1;
					if (sq_cnt_q == '0) begin
						if (st_q == S_SQ1) begin
							tkin_q <= sqrt_t;
							st_q <= S_R2SQ;
						end else begin
							del_q <= sqrt_t - tkin_q;
							st_q <= S_SEL;
						end
					end
				end
				S_SEL: begin
					cnt_q <= '0;
					rd_vld_q <= 1'b0;
					if (search) begin
						base_q <= '0;
						lim_q <= regs.entries - N_W'(1);
						dir_q <= 1'b0;
					end else begin
						// clamp the direct index to the last full bin
						if (kk > 16'(regs.entries - N_W'(2))) begin
							base_q <= IDX_W'(regs.entries - N_W'(2));
							stat_q <= ST_CLAMP;
						end else begin
							base_q <= kk[IDX_W-1:0];
						end
						lim_q <= N_W'(1);
						dir_q <= 1'b1;
					end
					st_q <= S_SCAN;
				end
				S_SCAN: begin
					rd_vld_q <= rd_en;
					if (rd_en) begin
						rdc_q <= cnt_q;
						cnt_q <= cnt_q + N_W'(1);
					end
					if (rd_vld_q) begin
						prev_e_q <= e_rd_q;
						prev_i_q <= i_rd_q;
						if ((rdc_q != '0) && (dir_q || (({1'b0, prev_e_q} < tkin_q) &&
							(tkin_q < {1'b0, e_rd_q})))) begin
							e0_q <= prev_e_q;
							e1_q <= e_rd_q;
							i0_q <= prev_i_q;
							i1_q <= i_rd_q;
							st_q <= S_NUM;
						end else if (rdc_q == lim_q) begin
							out_res_q <= '0;
							out_st_q <= ST_MISS;
							st_q <= S_OUT;
						end
					end
				end
				S_NUM: begin
					den_q <= ddiff[E_W] ? E_W'(~ddiff + 25'd1) : ddiff[E_W-1:0];
					qneg_q <= (ddiff != '0) && ((idiff[32] ^ ediff[25]) ^ ddiff[E_W]);
					rem_q <= '0;
					dv_cnt_q <= 6'(NUM_W - 1);
					if (ddiff == '0) begin
						quo_q <= '0;
						st_q <= S_FIX;
					end else begin
						quo_q <= mul_p[NUM_W-1:0];
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					// restoring division, one quotient bit per cycle
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= E_W'(rem_sh - {1'b0, den_q});
						quo_q <= {quo_q[NUM_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[E_W-1:0];
						quo_q <= {quo_q[NUM_W-2:0], 1'b0};
					end
					dv_cnt_q <= dv_cnt_q - 6'd1;
					if (dv_cnt_q == '0)
						st_q <= S_FIX;
				end
				S_FIX: begin
					if (qneg_q) begin
						if (quo_q > NUM_W'(i0_q))
							intens_q <= '0;
						else
							intens_q <= i0_q - quo_q[I_W-1:0];
					end else if (fix_sum[NUM_W:I_W] != '0) begin
						intens_q <= '1;
						sat_q <= 1'b1;
					end else begin
						intens_q <= fix_sum[I_W-1:0];
					end
					st_q <= S_PROD;
				end
				S_PROD: begin
					prod_q <= mul_p[NUM_W-1:0];
					st_q <= S_SCALE;
				end
				S_SCALE: begin
					if (sc_res[50:RES_W] != '0) begin
						out_res_q <= '1;
						out_st_q <= ST_SAT;
					end else begin
						out_res_q <= sc_res[RES_W-1:0];
						out_st_q <= sat_q ? ST_SAT : stat_q;
					end
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready)
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid = (st_q == S_OUT);
	assign rsp.intensity_per_mev = out_res_q;
	assign rsp.status = out_st_q;

	`RSI_ASSERT(a_miss_zero, (st_q == S_OUT) && (out_st_q == ST_MISS) |-> out_res_q == '0)
	`RSI_ASSERT(a_sat_max, (st_q == S_SCALE) && (sc_res[50:RES_W] != '0) |=> out_res_q == '1)
	`RSI_NEVER(a_scan_bound, (st_q == S_SCAN) && rd_vld_q && (rdc_q > lim_q))
endmodule

### src/rigidity_spectrum_intensity.sv
// Evaluate item: direct mode takes the bin from the scaled rigidity; search mode scans the table
// from entry 0 to a hit or to the entry count, and a miss skips the interpolation and scaling.
// Two 26-step square roots and a 57-step restoring division (skipped on a flat bin) do the work;
// the search reads one table entry a cycle. Load item: writes the entry and returns a zero result.
// One item is worked at a time; a two-item queue takes new items meanwhile.
// arst_n clears control state and loads the register reset values; tables are not cleared.
module rigidity_spectrum_intensity import rsi_pkg::*; (
	input logic clk,
	input logic arst_n,
	rsi_req_if.sink req,
	rsi_rsp_if.source rsp,
	rsi_cfg_if.sink cfg
);
	regs_t regs;
	logic item_vld;
	item_t item;
	logic item_pop;

	rsi_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cfg(cfg),
		.regs(regs),
		.item_vld(item_vld),
		.item(item),
		.item_pop(item_pop)
	);

	rsi_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.regs(regs),
		.item_vld(item_vld),
		.item(item),
		.item_pop(item_pop),
		.rsp(rsp)
	);
endmodule

### test/tb.sv
// Self-checking testbench for the rigidity spectrum intensity block
`timescale 1ns / 1ps

module tb;
	import rsi_pkg::*;

	localparam int LIMIT = 3000000;

	typedef struct {
		logic [RES_W-1:0] value;
		logic [ST_W-1:0] status;
	} outcome_t;

	typedef struct {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk;
	logic arst_n;

	rsi_req_if req();
	rsi_rsp_if rsp();
	rsi_cfg_if cfg();

	rigidity_spectrum_intensity u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg(cfg.sink)
	);

	// Own copy of the block state
	logic [E_W-1:0] energy_tab[TABLE_DEPTH];
	logic [I_W-1:0] intens_tab[TABLE_DEPTH];
	logic [E_W-1:0] rest_energy;
	logic [R_W-1:0] rig_step;
	logic [BPG_W-1:0] bins_per_gv;
	logic force_search;
	logic [N_W-1:0] entries;

	item_t pending_items[$];
	reg_write_t pending_writes[$];
	outcome_t expected_results[$];
	item_t cur_item;
	int unsigned send_gap;
	int unsigned recv_stall;
	logic bursty = 1'b0;
	logic nv;
	int errors = 0;
	int cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			probe = root | (64'd1 << b);
			if (probe * probe <= v)
				root = probe;
		end
		return root;
	endfunction

	function automatic longint unsigned kinetic(input longint unsigned r);
		longint unsigned t0;
		t0 = rest_energy;
		return int_sqrt(t0 * t0 + r * r) - t0;
	endfunction

	// Rigidity whose kinetic energy lies near the given energy
	function automatic logic [R_W-1:0] rigidity_for(input longint unsigned t);
		longint unsigned t0;
		longint unsigned r;
		t0 = rest_energy;
		r = int_sqrt((t + t0) * (t + t0) - t0 * t0);
		return (r > 64'hFFFFFF) ? R_W'(24'hFFFFFF) : R_W'(r);
	endfunction

	function automatic longint unsigned interpolate(input int k, input longint unsigned tk,
			inout logic sat);
		longint e0, e1, i0, i1, v;
		e0 = longint'(energy_tab[k]);
		e1 = longint'(energy_tab[k+1]);
		i0 = longint'(intens_tab[k]);
		i1 = longint'(intens_tab[k+1]);
		if (e1 == e0)
			v = i0;
		else
			v = i0 + ((i1 - i0) * (longint'(tk) - e0)) / (e1 - e0);
		if (v < 0)
			return 0;
		if (v > 64'hFFFFFFFF) begin
			sat = 1'b1;
			return 64'hFFFFFFFF;
		end
		return longint'(v);
	endfunction

	function automatic outcome_t spectrum_value(input item_t it);
		outcome_t o;
		longint unsigned tk, del, intens, prod, res, kk, r;
		int n;
		logic sat;
		logic found;
		o.value = '0;
		o.status = ST_OK;
		sat = 1'b0;
		intens = 0;
		if (it.func == FUNC_LOAD) begin
			energy_tab[it.entry_index] = it.entry_energy;
			intens_tab[it.entry_index] = it.entry_intensity;
			return o;
		end
		r = it.rigidity;
		tk = kinetic(r);
		del = kinetic(r + rig_step) - tk;
		n = entries;
		if (n < 2) n = 2;
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		if (bins_per_gv == 0 || force_search) begin
			found = 1'b0;
			for (int k = 0; k + 1 < n; k++) begin
				if (!found && tk > energy_tab[k] && tk < energy_tab[k+1]) begin
					intens = interpolate(k, tk, sat);
					found = 1'b1;
				end
			end
			if (!found) begin
				o.status = ST_MISS;
				return o;
			end
		end else begin
			kk = (r * bins_per_gv) >> 24;
			if (kk > n - 2) begin
				kk = n - 2;
				o.status = ST_CLAMP;
			end
			intens = interpolate(int'(kk), tk, sat);
		end
		prod = intens * del;
		res = (prod >> 16) * 1000 + (((prod & 64'hFFFF) * 1000) >> 16);
		if (res > 64'hFF_FFFF_FFFF) begin
			res = 64'hFF_FFFF_FFFF;
			sat = 1'b1;
		end
		if (sat)
			o.status = ST_SAT;
		o.value = res[RES_W-1:0];
		return o;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (bursty || p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (cycles % 150 == 0)
			bursty <= ($urandom_range(0, 3) == 0);
	end

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.func <= FUNC_LOAD;
			req.rigidity <= '0;
			req.entry_index <= '0;
			req.entry_energy <= '0;
			req.entry_intensity <= '0;
			send_gap = 0;
		end else begin
			nv = req.valid;
			if (req.valid && req.ready) begin
				expected_results.push_back(spectrum_value(cur_item));
				nv = 1'b0;
			end
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					req.func <= cur_item.func;
					req.rigidity <= cur_item.rigidity;
					req.entry_index <= cur_item.entry_index;
					req.entry_energy <= cur_item.entry_energy;
					req.entry_intensity <= cur_item.entry_intensity;
					nv = 1'b1;
					send_gap = pick_gap();
				end
			end
			req.valid <= nv;
		end
	end

	// Register write driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.valid <= 1'b0;
			cfg.index <= CFG_REST_ENERGY;
			cfg.data <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_REST_ENERGY: rest_energy = cfg.data[E_W-1:0];
					CFG_RIGIDITY_STEP: rig_step = cfg.data[R_W-1:0];
					CFG_BINS_PER_GV: bins_per_gv = cfg.data[BPG_W-1:0];
					CFG_FORCE_SEARCH: force_search = cfg.data[0];
					CFG_TABLE_ENTRIES: entries = cfg.data[N_W-1:0];
					default: ;
				endcase
			end
			if ((!cfg.valid || cfg.ready) && pending_writes.size() > 0) begin
				cfg.index <= pending_writes[0].index;
				cfg.data <= pending_writes[0].data;
				void'(pending_writes.pop_front());
				cfg.valid <= 1'b1;
			end else if (cfg.valid && cfg.ready) begin
				cfg.valid <= 1'b0;
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: intensity_per_mev %0d status %0d",
						rsp.intensity_per_mev, rsp.status);
					errors++;
				end else begin
					if (rsp.intensity_per_mev !== expected_results[0].value) begin
						$error("intensity_per_mev: expected %0d, got %0d",
							expected_results[0].value, rsp.intensity_per_mev);
						errors++;
					end
					if (rsp.status !== expected_results[0].status) begin
						$error("status: expected %0d, got %0d",
							expected_results[0].status, rsp.status);
						errors++;
					end
					void'(expected_results.pop_front());
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if (!bursty && $urandom_range(0, 3) == 0)
					recv_stall = pick_gap();
			end
		end
	end

	function automatic item_t load_item(input int idx, input logic [E_W-1:0] e,
			input logic [I_W-1:0] i);
		item_t it;
		it.func = FUNC_LOAD;
		it.rigidity = R_W'($urandom());
		it.entry_index = IDX_W'(idx);
		it.entry_energy = e;
		it.entry_intensity = i;
		return it;
	endfunction

	function automatic item_t eval_item(input logic [R_W-1:0] r);
		item_t it;
		it.func = FUNC_EVAL;
		it.rigidity = r;
		it.entry_index = IDX_W'($urandom());
		it.entry_energy = E_W'($urandom());
		it.entry_intensity = $urandom();
		return it;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		reg_write_t w;
		w.index = idx;
		w.data = d;
		pending_writes.push_back(w);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_items.size() > 0 || req.valid || expected_results.size() > 0
			|| pending_writes.size() > 0 || cfg.valid);
		repeat (8) @(posedge clk);
	endtask

	// Fill the whole table: ascending edges, sometimes flat or shuffled
	task automatic fill_table();
		longint unsigned e;
		int unsigned span;
		int unsigned shape;
		logic [I_W-1:0] iv;
		e = $urandom_range(0, 3000);
		span = 1 << $urandom_range(4, 18);
		shape = $urandom_range(0, 5);
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			case ($urandom_range(0, 3))
				0: iv = $urandom();
				1: iv = $urandom_range(0, 65535);
				2: iv = 32'hFFFFFFFF - $urandom_range(0, 4096);
				default: iv = $urandom_range(0, 32'h0FFFFFFF);
			endcase
			pending_items.push_back(load_item(k, (shape == 0) ? E_W'($urandom())
				: E_W'(e), iv));
			e = e + ((shape == 1 && $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, span));
			if (e > 64'hFFFFFF) e = 64'hFFFFFF;
		end
	endtask

	task automatic random_items(input int count);
		int k;
		for (int j = 0; j < count; j++) begin
			k = $urandom_range(0, TABLE_DEPTH - 1);
			case ($urandom_range(0, 9))
				0: pending_items.push_back(load_item($urandom_range(0, TABLE_DEPTH - 1),
					E_W'($urandom()), $urandom()));
				1, 2: pending_items.push_back(eval_item(R_W'($urandom()
					& ((1 << $urandom_range(1, 24)) - 1))));
				default: pending_items.push_back(eval_item(rigidity_for(
					energy_tab[k] + $urandom_range(0, 255))));
			endcase
		end
	endtask

	int unsigned phases[8][5] = '{
		'{61490, 655, 0, 1, 64},
		'{0, 1, 0, 0, 2},
		'{24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 0, 64},
		'{61490, 655, 256, 0, 64},
		'{3000, 20000, 1000, 0, 33},
		'{61490, 655, 300, 1, 127},
		'{200, 24'hFFFFFF, 16'h8000, 0, 0},
		'{0, 1, 1, 0, 1}
	};

	initial begin
		logic [R_W-1:0] r;
		arst_n = 1'b0;
		rest_energy = 61490;
		rig_step = 655;
		bins_per_gv = 0;
		force_search = 1'b1;
		entries = 64;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full table at reset settings, then edge cases
		fill_table();
		drain();
		pending_items.push_back(eval_item('0));
		pending_items.push_back(eval_item(24'hFFFFFF));
		pending_items.push_back(eval_item(rigidity_for(energy_tab[10] + 1)));
		r = rigidity_for(energy_tab[20] + 3);
		pending_items.push_back(load_item(0, E_W'(kinetic(r)), 32'hFFFFFFFF));
		pending_items.push_back(load_item(1, E_W'(kinetic(r) + 50), '0));
		pending_items.push_back(load_item(63, 24'hFFFFFF, 32'hFFFFFFFF));
		pending_items.push_back(eval_item(r));
		pending_items.push_back(eval_item(rigidity_for(kinetic(r) + 25)));
		pending_items.push_back(eval_item(rigidity_for(24'hFFFFF0)));
		drain();

		for (int p = 0; p < 8; p++) begin
			write_reg(CFG_REST_ENERGY, phases[p][0] | ($urandom() & 32'hFF000000));
			write_reg(CFG_RIGIDITY_STEP, phases[p][1]);
			write_reg(CFG_BINS_PER_GV, phases[p][2]);
			write_reg(CFG_FORCE_SEARCH, phases[p][3]);
			write_reg(CFG_TABLE_ENTRIES, phases[p][4]);
			drain();
			fill_table();
			random_items(140);
			drain();
		end

		repeat (300) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
